[rtl/bilinear_alpha_texture_sampler_defines.svh]
// assertion macros used by the checker file
`ifndef BILINEAR_ALPHA_TEXTURE_SAMPLER_DEFINES_SVH
`define BILINEAR_ALPHA_TEXTURE_SAMPLER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BATS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bats: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define BATS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bats: next-cycle check failed");

`endif

[rtl/bats_pkg.sv]
`default_nettype none

package bats_pkg;

    // fixed point format and field widths
    localparam int FRAC_BITS  = 16;
    localparam int W_W        = FRAC_BITS + 1;
    localparam int COORD_W    = FRAC_BITS + 2;
    localparam int TEXEL_W    = 16;

    // texel store and map geometry
    localparam int MAX_TEXELS = 4096;
    localparam int ADDR_W     = $clog2(MAX_TEXELS);
    localparam int MAX_SIDE   = 64;
    localparam int SIZE_W     = 7;
    localparam int SIDE_W     = $clog2(MAX_SIDE);
    localparam int PU_W       = W_W + SIDE_W;
    localparam int ROW_W      = SIDE_W + SIZE_W;

    // blend datapath
    localparam int PROD1_W    = TEXEL_W + W_W;
    localparam int PROD2_W    = PROD1_W + W_W;
    localparam int NUM_TAPS   = 4;
    localparam int TAP_W      = $clog2(NUM_TAPS);

    // result queue
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = OUTQ_PTR_W + 1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [W_W-1:0]    ONE      = W_W'(1) << FRAC_BITS;
    localparam logic [SIZE_W-1:0] SIDE_MAX = SIZE_W'(MAX_SIDE);

    // request operations
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_PRESENT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_ALPHA = 2'd3;

    // request after clamp and scale
    typedef struct packed {
        logic                op;
        logic                direct;
        logic [ADDR_W-1:0]   wr_addr;
        logic [TEXEL_W-1:0]  wr_data;
        logic [PU_W-1:0]     pu;
        logic [PU_W-1:0]     pv;
    } s1_item_t;

    // request ready for the texel memory port
    typedef struct packed {
        logic                            op;
        logic                            direct;
        logic [ADDR_W-1:0]               wr_addr;
        logic [TEXEL_W-1:0]              wr_data;
        logic [NUM_TAPS-1:0][ADDR_W-1:0] idx;
        logic [FRAC_BITS-1:0]            fu;
        logic [FRAC_BITS-1:0]            fv;
    } s2_item_t;

    // one blend term, travels alongside the texel read
    typedef struct packed {
        logic                valid;
        logic                direct;
        logic                first;
        logic                last;
        logic [W_W-1:0]      wu;
        logic [W_W-1:0]      wv;
        logic [TEXEL_W-1:0]  alpha;
    } term_t;

    // side register to the side in use: zero acts as one, large values saturate
    function automatic logic [SIZE_W-1:0] eff_side(input logic [SIZE_W-1:0] side);
        logic [SIZE_W-1:0] res;
        if (side == '0)
            res = SIZE_W'(1);
        else if (side > SIDE_MAX)
            res = SIDE_MAX;
        else
            res = side;
        return res;
    endfunction

    // signed Q1.16 clamped to [0, ONE]
    function automatic logic [W_W-1:0] clamp_coord(input logic [COORD_W-1:0] raw);
        logic [W_W-1:0] res;
        if (raw[COORD_W-1])
            res = '0;
        else if (raw[W_W-1:0] > ONE)
            res = ONE;
        else
            res = raw[W_W-1:0];
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/bats_texmem.sv]
`default_nettype none

module bats_texmem (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic                              we,
    input  wire logic [bats_pkg::ADDR_W-1:0]       addr,
    input  wire logic [bats_pkg::TEXEL_W-1:0]      wdata,
    output logic      [bats_pkg::TEXEL_W-1:0]      rdata
);

    logic [bats_pkg::TEXEL_W-1:0] mem [0:bats_pkg::MAX_TEXELS-1];
    logic [bats_pkg::TEXEL_W-1:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/bats_coord.sv]
`default_nettype none

module bats_coord (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  operation,
    input  wire logic        [bats_pkg::ADDR_W-1:0]    texel_address,
    input  wire logic        [bats_pkg::TEXEL_W-1:0]   texel_value,
    input  wire logic signed [bats_pkg::COORD_W-1:0]   u_coord,
    input  wire logic signed [bats_pkg::COORD_W-1:0]   v_coord,
    input  wire logic        [bats_pkg::SIZE_W-1:0]    map_width,
    input  wire logic        [bats_pkg::SIZE_W-1:0]    map_height,
    input  wire logic                                  map_present,
    output logic                                       s2_valid,
    output bats_pkg::s2_item_t                         s2_item,
    input  wire logic                                  s2_done
);

    logic [bats_pkg::SIZE_W-1:0]    w_eff;
    logic [bats_pkg::SIZE_W-1:0]    h_eff;
    logic [bats_pkg::SIZE_W-1:0]    w_m1;
    logic [bats_pkg::SIZE_W-1:0]    h_m1;
    logic [bats_pkg::W_W-1:0]       cu;
    logic [bats_pkg::W_W-1:0]       cv;
    logic                           in_accept;
    logic                           s2_load;

    bats_pkg::s1_item_t             s1_reg;
    bats_pkg::s1_item_t             s1_next;
    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    bats_pkg::s2_item_t             s2_reg;
    bats_pkg::s2_item_t             s2_next;
    logic                           s2_valid_reg;
    logic                           s2_valid_next;

    logic [bats_pkg::SIDE_W-1:0]    x1;
    logic [bats_pkg::SIDE_W-1:0]    y1;
    logic [bats_pkg::SIDE_W-1:0]    x2;
    logic [bats_pkg::SIDE_W-1:0]    y2;
    logic [bats_pkg::SIZE_W-1:0]    x2_raw;
    logic [bats_pkg::SIZE_W-1:0]    y2_raw;
    logic [bats_pkg::FRAC_BITS-1:0] fu;
    logic [bats_pkg::FRAC_BITS-1:0] fv;
    logic [bats_pkg::ROW_W-1:0]     row1;
    logic [bats_pkg::ROW_W-1:0]     row2;

    // effective map size
    assign w_eff = bats_pkg::eff_side(map_width);
    assign h_eff = bats_pkg::eff_side(map_height);
    assign w_m1  = w_eff - bats_pkg::SIZE_W'(1);
    assign h_m1  = h_eff - bats_pkg::SIZE_W'(1);

    // handshake between the two stages
    assign s2_load   = s1_valid_reg && (!s2_valid_reg || s2_done);
    assign in_ready  = !s1_valid_reg || !s2_valid_reg || s2_done;
    assign in_accept = in_valid && in_ready;

    // stage 1: clamp and scale by side minus one
    assign cu = bats_pkg::clamp_coord(u_coord);
    assign cv = bats_pkg::clamp_coord(v_coord);

    always_comb
    begin
        s1_next.op      = operation;
        s1_next.direct  = !map_present;
        s1_next.wr_addr = texel_address;
        s1_next.wr_data = texel_value;
        s1_next.pu      = bats_pkg::PU_W'(cu) * bats_pkg::PU_W'(w_m1[bats_pkg::SIDE_W-1:0]);
        s1_next.pv      = bats_pkg::PU_W'(cv) * bats_pkg::PU_W'(h_m1[bats_pkg::SIDE_W-1:0]);
    end

    // stage 2: neighbor positions and fractions
    assign x1 = s1_reg.pu[bats_pkg::FRAC_BITS +: bats_pkg::SIDE_W];
    assign y1 = s1_reg.pv[bats_pkg::FRAC_BITS +: bats_pkg::SIDE_W];
    assign fu = s1_reg.pu[bats_pkg::FRAC_BITS-1:0];
    assign fv = s1_reg.pv[bats_pkg::FRAC_BITS-1:0];

    // on an integer position the neighbor is the texel itself
    assign x2_raw = bats_pkg::SIZE_W'(x1) + bats_pkg::SIZE_W'(fu != '0);
    assign y2_raw = bats_pkg::SIZE_W'(y1) + bats_pkg::SIZE_W'(fv != '0);
    assign x2 = (x2_raw > w_m1) ? w_m1[bats_pkg::SIDE_W-1:0] : x2_raw[bats_pkg::SIDE_W-1:0];
    assign y2 = (y2_raw > h_m1) ? h_m1[bats_pkg::SIDE_W-1:0] : y2_raw[bats_pkg::SIDE_W-1:0];

    // row bases, row-major
    assign row1 = bats_pkg::ROW_W'(y1) * bats_pkg::ROW_W'(w_eff);
    assign row2 = bats_pkg::ROW_W'(y2) * bats_pkg::ROW_W'(w_eff);

    // texel indices wrap modulo the store depth
    always_comb
    begin
        s2_next.op      = s1_reg.op;
        s2_next.direct  = s1_reg.direct;
        s2_next.wr_addr = s1_reg.wr_addr;
        s2_next.wr_data = s1_reg.wr_data;
        s2_next.fu      = fu;
        s2_next.fv      = fv;
        s2_next.idx[0]  = bats_pkg::ADDR_W'(row1 + bats_pkg::ROW_W'(x1));
        s2_next.idx[1]  = bats_pkg::ADDR_W'(row1 + bats_pkg::ROW_W'(x2));
        s2_next.idx[2]  = bats_pkg::ADDR_W'(row2 + bats_pkg::ROW_W'(x1));
        s2_next.idx[3]  = bats_pkg::ADDR_W'(row2 + bats_pkg::ROW_W'(x2));
    end

    // stage occupancy
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s2_load)
            s1_valid_next = 1'b0;

        s2_valid_next = s2_valid_reg;
        if (s2_load)
            s2_valid_next = 1'b1;
        else if (s2_done)
            s2_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_reg <= s1_next;
        if (s2_load)
            s2_reg <= s2_next;
    end

    assign s2_valid = s2_valid_reg;
    assign s2_item  = s2_reg;

endmodule

`default_nettype wire

[rtl/bats_blend.sv]
`default_nettype none

module bats_blend (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire bats_pkg::term_t                   issue,
    input  wire logic [bats_pkg::TEXEL_W-1:0]      rdata,
    output logic                                   res_valid,
    output logic      [bats_pkg::TEXEL_W-1:0]      res_alpha
);

    bats_pkg::term_t                t0_reg;
    bats_pkg::term_t                t1_reg;
    bats_pkg::term_t                t2_reg;
    logic [bats_pkg::PROD1_W-1:0]   prod1_reg;
    logic [bats_pkg::PROD1_W-1:0]   prod1_next;
    logic [bats_pkg::PROD2_W-1:0]   prod2_reg;
    logic [bats_pkg::PROD2_W-1:0]   prod2_next;
    logic [bats_pkg::PROD2_W-1:0]   acc_reg;
    logic [bats_pkg::PROD2_W-1:0]   acc_next;

    // term tags follow the read data down the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_reg <= '0;
            t1_reg <= '0;
            t2_reg <= '0;
        end
        else
        begin
            t0_reg <= issue;
            t1_reg <= t0_reg;
            t2_reg <= t1_reg;
        end
    end

    // texel times horizontal weight, then times vertical weight
    assign prod1_next = bats_pkg::PROD1_W'(rdata) * bats_pkg::PROD1_W'(t0_reg.wu);
    assign prod2_next = bats_pkg::PROD2_W'(prod1_reg) * bats_pkg::PROD2_W'(t1_reg.wv);

    // four terms summed exactly, floor taken once at the end
    assign acc_next = t2_reg.first ? prod2_reg : acc_reg + prod2_reg;

    always_ff @(posedge clk)
    begin
        prod1_reg <= prod1_next;
        prod2_reg <= prod2_next;
        if (t2_reg.valid)
            acc_reg <= acc_next;
    end

    assign res_valid = t2_reg.valid && t2_reg.last;
    assign res_alpha = t2_reg.direct ? t2_reg.alpha
                                     : acc_next[2*bats_pkg::FRAC_BITS +: bats_pkg::TEXEL_W];

endmodule

`default_nettype wire

[rtl/bats_outq.sv]
`default_nettype none

module bats_outq (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    input  wire logic [bats_pkg::TEXEL_W-1:0]      push_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [bats_pkg::TEXEL_W-1:0]      out_data
);

    logic [bats_pkg::TEXEL_W-1:0]    slot [0:bats_pkg::OUTQ_DEPTH-1];
    logic [bats_pkg::OUTQ_PTR_W-1:0] wr_ptr_reg;
    logic [bats_pkg::OUTQ_PTR_W-1:0] wr_ptr_next;
    logic [bats_pkg::OUTQ_PTR_W-1:0] rd_ptr_reg;
    logic [bats_pkg::OUTQ_PTR_W-1:0] rd_ptr_next;
    logic [bats_pkg::OUTQ_CNT_W-1:0] cnt_reg;
    logic [bats_pkg::OUTQ_CNT_W-1:0] cnt_next;
    logic                            pop;

    // space is reserved upstream, so a push always finds a free slot
    assign pop = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + bats_pkg::OUTQ_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + bats_pkg::OUTQ_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + bats_pkg::OUTQ_CNT_W'(push) - bats_pkg::OUTQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot[wr_ptr_reg] <= push_data;
    end

    assign out_valid = cnt_reg != '0;
    assign out_data  = slot[rd_ptr_reg];

endmodule

`default_nettype wire

[rtl/bilinear_alpha_texture_sampler.sv]
// channel   handshake              payload
// input     in_valid / in_ready    operation, texel_address, texel_value, u_coord, v_coord
// output    out_valid / out_ready  alpha_value
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each request passes the clamp stage and the index stage, then the issue stage, where a write
// makes a single memory access, a sample without a map a single blend term, and a sample with
// a map four neighbor reads. A map sample holds the issue stage until its last read is issued;
// writes and unmapped samples issue one per cycle unless a sample waits for result space.
// Reset clears control and loads the register defaults; the texel memory is not cleared.
// A sample holds the issue stage while four results are reserved; one more request is taken.
`default_nettype none

module bilinear_alpha_texture_sampler (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  operation,
    input  wire logic        [bats_pkg::ADDR_W-1:0]    texel_address,
    input  wire logic        [bats_pkg::TEXEL_W-1:0]   texel_value,
    input  wire logic signed [bats_pkg::COORD_W-1:0]   u_coord,
    input  wire logic signed [bats_pkg::COORD_W-1:0]   v_coord,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic             [bats_pkg::TEXEL_W-1:0]   alpha_value,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic        [bats_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [bats_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [bats_pkg::SIZE_W-1:0]     map_width_reg;
    logic [bats_pkg::SIZE_W-1:0]     map_width_next;
    logic [bats_pkg::SIZE_W-1:0]     map_height_reg;
    logic [bats_pkg::SIZE_W-1:0]     map_height_next;
    logic                            map_present_reg;
    logic                            map_present_next;
    logic [bats_pkg::TEXEL_W-1:0]    object_alpha_reg;
    logic [bats_pkg::TEXEL_W-1:0]    object_alpha_next;

    logic                            s2_valid;
    bats_pkg::s2_item_t              s2_item;
    logic                            s2_done;
    logic [bats_pkg::TAP_W-1:0]      phase_reg;
    logic [bats_pkg::TAP_W-1:0]      phase_next;
    logic [bats_pkg::OUTQ_CNT_W-1:0] credit_reg;
    logic [bats_pkg::OUTQ_CNT_W-1:0] credit_next;
    logic                            credit_ok;
    logic                            issue_res;
    logic                            out_pop;
    bats_pkg::term_t                 term;

    logic                            mem_en;
    logic                            mem_we;
    logic [bats_pkg::ADDR_W-1:0]     mem_addr;
    logic [bats_pkg::TEXEL_W-1:0]    mem_rdata;
    logic                            res_valid;
    logic [bats_pkg::TEXEL_W-1:0]    res_alpha;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        map_width_next    = map_width_reg;
        map_height_next   = map_height_reg;
        map_present_next  = map_present_reg;
        object_alpha_next = object_alpha_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                bats_pkg::CFG_MAP_WIDTH:    map_width_next    = cfg_data[bats_pkg::SIZE_W-1:0];
                bats_pkg::CFG_MAP_HEIGHT:   map_height_next   = cfg_data[bats_pkg::SIZE_W-1:0];
                bats_pkg::CFG_MAP_PRESENT:  map_present_next  = cfg_data[0];
                bats_pkg::CFG_OBJECT_ALPHA: object_alpha_next = cfg_data[bats_pkg::TEXEL_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg    <= bats_pkg::SIZE_W'(1);
            map_height_reg   <= bats_pkg::SIZE_W'(1);
            map_present_reg  <= 1'b0;
            object_alpha_reg <= '1;
        end
        else
        begin
            map_width_reg    <= map_width_next;
            map_height_reg   <= map_height_next;
            map_present_reg  <= map_present_next;
            object_alpha_reg <= object_alpha_next;
        end
    end

    // clamp, scale and index stages
    bats_coord u_coord_pipe (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .texel_address (texel_address),
        .texel_value   (texel_value),
        .u_coord       (u_coord),
        .v_coord       (v_coord),
        .map_width     (map_width_reg),
        .map_height    (map_height_reg),
        .map_present   (map_present_reg),
        .s2_valid      (s2_valid),
        .s2_item       (s2_item),
        .s2_done       (s2_done)
    );

    // issue stage: requests use the memory port strictly in order, so a write is
    // always seen by every later read without forwarding
    assign credit_ok = credit_reg < bats_pkg::OUTQ_CNT_W'(bats_pkg::OUTQ_DEPTH);

    always_comb
    begin
        term       = '0;
        mem_en     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = s2_item.wr_addr;
        s2_done    = 1'b0;
        issue_res  = 1'b0;
        phase_next = phase_reg;
        if (s2_valid)
        begin
            if (s2_item.op == bats_pkg::OP_WRITE)
            begin
                mem_en  = 1'b1;
                mem_we  = 1'b1;
                s2_done = 1'b1;
            end
            else if (s2_item.direct)
            begin
                // no map: object alpha goes down the pipe as a single term
                if (credit_ok)
                begin
                    term.valid  = 1'b1;
                    term.direct = 1'b1;
                    term.first  = 1'b1;
                    term.last   = 1'b1;
                    term.alpha  = object_alpha_reg;
                    issue_res   = 1'b1;
                    s2_done     = 1'b1;
                end
            end
            else if (phase_reg != '0 || credit_ok)
            begin
                // one neighbor read per cycle, result slot reserved on the first
                mem_en     = 1'b1;
                mem_addr   = s2_item.idx[phase_reg];
                term.valid = 1'b1;
                term.first = phase_reg == '0;
                term.last  = phase_reg == bats_pkg::TAP_W'(bats_pkg::NUM_TAPS - 1);
                term.wu    = phase_reg[0] ? bats_pkg::W_W'(s2_item.fu)
                                          : bats_pkg::ONE - bats_pkg::W_W'(s2_item.fu);
                term.wv    = phase_reg[1] ? bats_pkg::W_W'(s2_item.fv)
                                          : bats_pkg::ONE - bats_pkg::W_W'(s2_item.fv);
                issue_res  = phase_reg == '0;
                phase_next = phase_reg + bats_pkg::TAP_W'(1);
                s2_done    = term.last;
            end
        end
    end

    // results reserved in the queue and not yet taken
    assign out_pop     = out_valid && out_ready;
    assign credit_next = credit_reg + bats_pkg::OUTQ_CNT_W'(issue_res)
                                    - bats_pkg::OUTQ_CNT_W'(out_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            credit_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            credit_reg <= credit_next;
        end
    end

    bats_texmem u_texmem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (s2_item.wr_data),
        .rdata (mem_rdata)
    );

    bats_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (term),
        .rdata     (mem_rdata),
        .res_valid (res_valid),
        .res_alpha (res_alpha)
    );

    bats_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res_alpha),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (alpha_value)
    );

endmodule

`default_nettype wire

[rtl/bats_chk.sv]
`default_nettype none
`include "bilinear_alpha_texture_sampler_defines.svh"

module bats_chk (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic                              in_ready,
    input  wire logic                              operation,
    input  wire logic                              out_valid,
    input  wire logic                              out_ready,
    input  wire logic [bats_pkg::TEXEL_W-1:0]      alpha_value
);

    localparam int PEND_W      = 4;
    localparam int MAX_PENDING = bats_pkg::OUTQ_DEPTH + 2;

    logic [PEND_W-1:0] pending_reg;
    logic [PEND_W-1:0] pending_next;
    logic              sample_acc;
    logic              out_acc;

    // samples accepted whose result has not been taken
    assign sample_acc   = in_valid && in_ready && (operation == bats_pkg::OP_SAMPLE);
    assign out_acc      = out_valid && out_ready;
    assign pending_next = pending_reg + PEND_W'(sample_acc) - PEND_W'(out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // a waiting result holds its value
    `BATS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(alpha_value))

    // a result only ever belongs to an accepted sample
    `BATS_ASSERT_IMPL(a_no_orphan_result, clk, rst_n, out_valid, pending_reg != '0)

    // with no sample outstanding, writes never block the input
    `BATS_ASSERT_IMPL(a_ready_when_idle, clk, rst_n, pending_reg == '0, in_ready)

    // queue reservation plus the two front stages bound the samples in flight
    `BATS_ASSERT_IMPL(a_pending_bound, clk, rst_n, 1'b1, pending_reg <= PEND_W'(MAX_PENDING))

endmodule

bind bilinear_alpha_texture_sampler bats_chk u_bats_chk (.*);

`default_nettype wire

[tb/tb_bilinear_alpha_texture_sampler.sv]
`timescale 1ns / 100ps

module tb_bilinear_alpha_texture_sampler;
    import bats_pkg::*;

    localparam int SETTLE_CYCLES  = 32;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 50;
    localparam int Q16_UNIT       = 65536;
    localparam int DIRECTED_COUNT = 22;

    typedef enum logic {ROW_REG, ROW_REQ} row_kind_e;

    // one directed step: a register write or a request
    typedef struct packed {
        row_kind_e              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_data;
        logic                   op;
        logic [ADDR_W-1:0]      addr;
        logic [TEXEL_W-1:0]     texel;
        logic [COORD_W-1:0]     u;
        logic [COORD_W-1:0]     v;
        logic                   typed;
        logic [TEXEL_W-1:0]     alpha;
    } stim_row_t;

    // reset defaults, absent map, clamp, integer position, side limits, address extreme
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{ROW_REQ, CFG_MAP_WIDTH,    16'h0000, OP_SAMPLE, 12'h000, 16'h0000,
          18'h00000, 18'h00000, 1'b1, 16'hFFFF},
        '{ROW_REG, CFG_OBJECT_ALPHA, 16'h0000, OP_WRITE,  12'h000, 16'h0000,
          18'h00000, 18'h00000, 1'b0, 16'h0000},
        '{ROW_REQ, CFG_MAP_WIDTH,    16'h0000, OP_SAMPLE, 12'h000, 16'h0000,
          18'h20000, 18'h1FFFF, 1'b1, 16'h0000},
        '{ROW_REG, CFG_MAP_PRESENT,  16'h0001, OP_WRITE,  12'h000, 16'h0000,
          18'h00000, 18'h00000, 1'b0, 16'h0000},
        '{ROW_REQ, CFG_MAP_WIDTH,    16'h0000, OP_WRITE,  12'h000, 16'hFFFF,
          18'h00000, 18'h00000, 1'b0, 16'h0000},
        '{ROW_REQ, CFG_MAP_WIDTH,    16'h0000, OP_SAMPLE, 12'h000, 16'h0000,
          18'h1FFFF, 18'h3FFFF, 1'b1, 16'hFFFF},
        '{ROW_REG, CFG_MAP_WIDTH,    16'h0002, OP_WRITE,  12'h000, 16'h0000,
          18'h00000, 18'h00000, 1'b0, 16'h0000},
        '{ROW_REQ, CFG_MAP_WIDTH,    16'h0000, OP_WRITE,  12'h001, 16'h0000,
          18'h00000, 18'h00000, 1'b0, 16'h0000},
        '{ROW_REQ, CFG_MAP_WIDTH,    16'h0000, OP_SAMPLE, 12'h000, 16'h0000,
          18'h08000, 18'h00000, 1'b1, 16'h7FFF},
        '{ROW_REQ, CFG_MAP_WIDTH,    16'h0000, OP_SAMPLE, 12'h000, 16'h0000,
          18'h10000, 18'h00000, 1'b1, 16'h0000},
        '{ROW_REQ, CFG_MAP_WIDTH,    16'h0000, OP_SAMPLE, 12'h000, 16'h0000,
          18'h1FFFF, 18'h00000, 1'b1, 16'h0000},
        '{ROW_REQ, CFG_MAP_WIDTH,    16'h0000, OP_SAMPLE, 12'h000, 16'h0000,
          18'h0C000, 18'h08000, 1'b0, 16'h0000},
        '{ROW_REG, CFG_MAP_WIDTH,    16'hFF80, OP_WRITE,  12'h000, 16'h0000,
          18'h00000, 18'h00000, 1'b0, 16'h0000},
        '{ROW_REQ, CFG_MAP_WIDTH,    16'h0000, OP_SAMPLE, 12'h000, 16'h0000,
          18'h1FFFF, 18'h00000, 1'b1, 16'hFFFF},
        '{ROW_REG, CFG_MAP_WIDTH,    16'h007F, OP_WRITE,  12'h000, 16'h0000,
          18'h00000, 18'h00000, 1'b0, 16'h0000},
        '{ROW_REQ, CFG_MAP_WIDTH,    16'h0000, OP_WRITE,  12'h03F, 16'h00FF,
          18'h00000, 18'h00000, 1'b0, 16'h0000},
        '{ROW_REQ, CFG_MAP_WIDTH,    16'h0000, OP_SAMPLE, 12'h000, 16'h0000,
          18'h10000, 18'h00000, 1'b1, 16'h00FF},
        '{ROW_REG, CFG_MAP_HEIGHT,   16'h0040, OP_WRITE,  12'h000, 16'h0000,
          18'h00000, 18'h00000, 1'b0, 16'h0000},
        '{ROW_REQ, CFG_MAP_WIDTH,    16'h0000, OP_WRITE,  12'hFFF, 16'hABCD,
          18'h00000, 18'h00000, 1'b0, 16'h0000},
        '{ROW_REQ, CFG_MAP_WIDTH,    16'h0000, OP_SAMPLE, 12'h000, 16'h0000,
          18'h10000, 18'h10000, 1'b1, 16'hABCD},
        '{ROW_REG, CFG_MAP_PRESENT,  16'hFFFE, OP_WRITE,  12'h000, 16'h0000,
          18'h00000, 18'h00000, 1'b0, 16'h0000},
        '{ROW_REQ, CFG_MAP_WIDTH,    16'h0000, OP_SAMPLE, 12'h000, 16'h0000,
          18'h08000, 18'h08000, 1'b1, 16'h0000}
    };

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic                        operation;
    logic        [ADDR_W-1:0]    texel_address;
    logic        [TEXEL_W-1:0]   texel_value;
    logic signed [COORD_W-1:0]   u_coord;
    logic signed [COORD_W-1:0]   v_coord;
    logic                        out_valid;
    logic                        out_ready;
    logic        [TEXEL_W-1:0]   alpha_value;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic        [CFG_IDX_W-1:0] cfg_index;
    logic        [CFG_DATA_W-1:0] cfg_data;

    // mirror of the block's registers and texel memory
    logic [SIZE_W-1:0]  cur_width;
    logic [SIZE_W-1:0]  cur_height;
    logic               cur_present;
    logic [TEXEL_W-1:0] cur_obj_alpha;
    logic [TEXEL_W-1:0] texel_mirror [MAX_TEXELS];
    bit                 texel_loaded [MAX_TEXELS];

    logic [TEXEL_W-1:0] pending_alpha [$];
    int                 mismatch_count;
    int                 item_count;
    bit                 idle_enable;

    bilinear_alpha_texture_sampler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .texel_address (texel_address),
        .texel_value   (texel_value),
        .u_coord       (u_coord),
        .v_coord       (v_coord),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .alpha_value   (alpha_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // side register value to the side actually used
    function automatic int side_in_use(input logic [SIZE_W-1:0] side);
        int s;
        s = side;
        if (s < 1)
        begin
            s = 1;
        end
        else if (s > MAX_SIDE)
        begin
            s = MAX_SIDE;
        end
        return s;
    endfunction

    // signed Q1.16 to [0, 1.0]
    function automatic int clamp_q16(input logic [COORD_W-1:0] raw);
        int c;
        c = $signed(raw);
        if (c < 0)
        begin
            c = 0;
        end
        else if (c > Q16_UNIT)
        begin
            c = Q16_UNIT;
        end
        return c;
    endfunction

    // four neighbor texel indexes and the neighbor weights of a sample
    function automatic void locate_taps(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
                                        output int taps [4], output int wu, output int wv);
        int w, h, pu, pv, x1, y1, x2, y2;
        w  = side_in_use(cur_width);
        h  = side_in_use(cur_height);
        pu = clamp_q16(u) * (w - 1);
        pv = clamp_q16(v) * (h - 1);
        x1 = pu >> FRAC_BITS;
        y1 = pv >> FRAC_BITS;
        wu = pu & (Q16_UNIT - 1);
        wv = pv & (Q16_UNIT - 1);
        x2 = (wu != 0) ? x1 + 1 : x1;
        y2 = (wv != 0) ? y1 + 1 : y1;
        if (x2 > w - 1)
        begin
            x2 = w - 1;
        end
        if (y2 > h - 1)
        begin
            y2 = h - 1;
        end
        taps[0] = (y1 * w + x1) % MAX_TEXELS;
        taps[1] = (y1 * w + x2) % MAX_TEXELS;
        taps[2] = (y2 * w + x1) % MAX_TEXELS;
        taps[3] = (y2 * w + x2) % MAX_TEXELS;
    endfunction

    // bilinear blend, floor to Q0.16, or the object alpha without a map
    function automatic logic [TEXEL_W-1:0] predict_alpha(input logic [COORD_W-1:0] u,
                                                         input logic [COORD_W-1:0] v);
        int         taps [4];
        int         wu, wv;
        logic [63:0] row_a, row_b, total;
        if (!cur_present)
        begin
            return cur_obj_alpha;
        end
        locate_taps(u, v, taps, wu, wv);
        row_a = 64'(texel_mirror[taps[0]]) * 64'(Q16_UNIT - wu)
              + 64'(texel_mirror[taps[1]]) * 64'(wu);
        row_b = 64'(texel_mirror[taps[2]]) * 64'(Q16_UNIT - wu)
              + 64'(texel_mirror[taps[3]]) * 64'(wu);
        total = row_a * 64'(Q16_UNIT - wv) + row_b * 64'(wv);
        return total[47:32];
    endfunction

    // random coordinate: edges, below zero, above one, inside, anything
    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 18'h00000;
            1: return 18'h10000;
            2: return 18'(0 - int'($urandom_range(1, 131072)));
            3: return 18'($urandom_range(65537, 131071));
            4: return 18'($urandom);
            default: return 18'($urandom_range(0, 65536));
        endcase
    endfunction

    // side register value, mostly small, sometimes out of range
    function automatic logic [SIZE_W-1:0] pick_side();
        case ($urandom_range(0, 11))
            0: return 7'd0;
            1: return 7'd127;
            2: return 7'd64;
            3: return 7'($urandom_range(65, 126));
            4: return 7'($urandom_range(7, 63));
            default: return 7'($urandom_range(1, 6));
        endcase
    endfunction

    // send one request, updating the mirror or queuing its alpha
    task automatic push_request(input logic op, input logic [ADDR_W-1:0] addr,
                                input logic [TEXEL_W-1:0] texel,
                                input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
                                input logic typed, input logic [TEXEL_W-1:0] typed_alpha);
        int gap;
        gap = idle_enable ? $urandom_range(0, 3) : 0;
        if (op == OP_WRITE)
        begin
            texel_mirror[addr] = texel;
            texel_loaded[addr] = 1'b1;
        end
        else
        begin
            pending_alpha.push_back(typed ? typed_alpha : predict_alpha(u, v));
        end
        item_count++;
        cfg_valid <= 1'b0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        operation     <= op;
        texel_address <= addr;
        texel_value   <= texel;
        u_coord       <= u;
        v_coord       <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // register write, only while the block is idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_MAP_WIDTH:    cur_width = data[SIZE_W-1:0];
            CFG_MAP_HEIGHT:   cur_height = data[SIZE_W-1:0];
            CFG_MAP_PRESENT:  cur_present = data[0];
            CFG_OBJECT_ALPHA: cur_obj_alpha = data;
            default: ;
        endcase
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // drop valids, wait for every outstanding alpha, then let writes drain
    task automatic settle();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_alpha.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side: random stalls, compare against the oldest expected alpha
    initial
    begin
        logic [TEXEL_W-1:0] want;
        int                 gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = idle_enable ? $urandom_range(0, 3) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if (pending_alpha.size() == 0)
            begin
                $error("alpha_value with no sample outstanding: actual %h", alpha_value);
                mismatch_count++;
            end
            else
            begin
                want = pending_alpha.pop_front();
                if (alpha_value !== want)
                begin
                    $error("alpha_value mismatch: expected %h, actual %h", want, alpha_value);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        stim_row_t          row;
        row_kind_e          prev_kind;
        int                 start_count;
        int                 taps [4];
        int                 wu, wv;
        logic [COORD_W-1:0] u_pick, v_pick;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        operation     = OP_WRITE;
        texel_address = '0;
        texel_value   = '0;
        u_coord       = '0;
        v_coord       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_MAP_WIDTH;
        cfg_data      = '0;
        cur_width     = 7'd1;
        cur_height    = 7'd1;
        cur_present   = 1'b0;
        cur_obj_alpha = 16'hFFFF;
        mismatch_count = 0;
        item_count    = 0;
        idle_enable   = 1'b1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        prev_kind = ROW_REG;
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_REG)
            begin
                if (prev_kind == ROW_REQ)
                begin
                    settle();
                end
                write_register(row.reg_idx, row.reg_data);
            end
            else
            begin
                push_request(row.op, row.addr, row.texel, row.u, row.v, row.typed, row.alpha);
            end
            prev_kind = row.kind;
        end

        // random phases, each under a fresh register setting
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            settle();
            idle_enable = (phase % 3 != 2);
            write_register(CFG_MAP_WIDTH, {9'($urandom), pick_side()});
            write_register(CFG_MAP_HEIGHT, {9'($urandom), pick_side()});
            write_register(CFG_MAP_PRESENT, {15'($urandom), 1'($urandom_range(0, 4) != 0)});
            case ($urandom_range(0, 3))
                0: write_register(CFG_OBJECT_ALPHA, 16'h0000);
                1: write_register(CFG_OBJECT_ALPHA, 16'hFFFF);
                default: write_register(CFG_OBJECT_ALPHA, 16'($urandom));
            endcase
            start_count = item_count;
            while (item_count - start_count < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 3)
                begin
                    push_request(OP_WRITE, 12'($urandom), 16'($urandom), 18'($urandom),
                                 18'($urandom), 1'b0, 16'h0000);
                end
                else
                begin
                    u_pick = rand_coord();
                    v_pick = rand_coord();
                    // load any neighbor texel not yet written
                    if (cur_present)
                    begin
                        locate_taps(u_pick, v_pick, taps, wu, wv);
                        for (int k = 0; k < 4; k++)
                        begin
                            if (!texel_loaded[taps[k]])
                            begin
                                push_request(OP_WRITE, 12'(taps[k]), 16'($urandom),
                                             18'($urandom), 18'($urandom), 1'b0, 16'h0000);
                            end
                        end
                    end
                    push_request(OP_SAMPLE, 12'($urandom), 16'($urandom), u_pick, v_pick,
                                 1'b0, 16'h0000);
                end
            end
        end

        settle();
        if (mismatch_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/bats_pkg.sv
rtl/bats_texmem.sv
rtl/bats_coord.sv
rtl/bats_blend.sv
rtl/bats_outq.sv
rtl/bilinear_alpha_texture_sampler.sv
rtl/bats_chk.sv
tb/tb_bilinear_alpha_texture_sampler.sv
